[rtl/crcfp_pkg.sv]
// Shared types, constants and the CRC-16/CCITT byte update for the frame parser.
`timescale 1ns / 1ps
package crcfp_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  StartByteRst  = 8'h00;
  localparam logic [15:0] MaxPayloadRst = 16'd256;
  localparam logic [15:0] CrcSeedRst    = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'h1021;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_BYTE  = 2'd0,
    CFG_MAX_PAYLOAD = 2'd1,
    CFG_CRC_SEED    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_GOOD    = 2'd1,
    ST_BADCRC  = 2'd2,
    ST_TOOLONG = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [15:0] max_payload;
    logic [15:0] crc_seed;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [7:0]  frame_seq;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
  } result_t;

  // One byte through the CRC, MSB first, no reflection.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[rtl/crcfp_cfg_regs.sv]
// Configuration registers of the frame parser.
`timescale 1ns / 1ps
module crcfp_cfg_regs
  import crcfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_BYTE:  cfg_d.start_byte  = cfg_data_i[7:0];
        CFG_MAX_PAYLOAD: cfg_d.max_payload = cfg_data_i;
        CFG_CRC_SEED:    cfg_d.crc_seed    = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= StartByteRst;
      cfg_q.max_payload <= MaxPayloadRst;
      cfg_q.crc_seed    <= CrcSeedRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/crcfp_parser.sv]
// Frame parsing state machine: phase, length, payload count and running CRC.
`timescale 1ns / 1ps
module crcfp_parser
  import crcfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output result_t    res_o
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_SEQ     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CRC_LO  = 3'd6,
    PH_CRC_HI  = 3'd7
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] crc_upd;
  logic [15:0] len_hi_asm;
  logic [15:0] cnt_inc;
  logic        finish;
  status_e     status;

  assign crc_upd    = crc16_byte(crc_q, byte_i);
  assign len_hi_asm = {byte_i, len_q[7:0]};
  assign cnt_inc    = cnt_q + 16'd1;

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    type_d   = type_q;
    seq_d    = seq_q;
    status   = ST_BUSY;
    finish   = 1'b0;
    res_o    = '0;

    unique case (phase_q)
      PH_HUNT: begin
        if (byte_i == cfg_i.start_byte) begin
          crc_d   = cfg_i.crc_seed;
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_d  = byte_i;
        crc_d   = crc_upd;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d   = {8'h00, byte_i};
        crc_d   = crc_upd;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d = len_hi_asm;
        crc_d = crc_upd;
        if (len_hi_asm > cfg_i.max_payload) begin
          status = ST_TOOLONG;
          finish = 1'b1;
        end else begin
          phase_d = PH_SEQ;
        end
      end
      PH_SEQ: begin
        seq_d   = byte_i;
        crc_d   = crc_upd;
        cnt_d   = '0;
        phase_d = (len_q == '0) ? PH_CRC_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = byte_i;
        res_o.payload_index = cnt_q;
        crc_d = crc_upd;
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_d = byte_i;
        phase_d  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        status = ({byte_i, crc_lo_q} == crc_q) ? ST_GOOD : ST_BADCRC;
        finish = 1'b1;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase

    // Result shows the length as assembled, before a frame end clears it.
    res_o.status       = status;
    res_o.frame_type   = type_d;
    res_o.frame_length = len_d;
    res_o.frame_seq    = seq_d;

    if (finish) begin
      phase_d  = PH_HUNT;
      len_d    = '0;
      cnt_d    = '0;
      crc_lo_d = '0;
      crc_d    = cfg_i.crc_seed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      len_q    <= '0;
      cnt_q    <= '0;
      crc_q    <= CrcSeedRst;
      crc_lo_q <= '0;
      type_q   <= '0;
      seq_q    <= '0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      type_q   <= type_d;
      seq_q    <= seq_d;
    end
  end

  a_end_to_hunt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && res_o.status != ST_BUSY) |=> (phase_q == PH_HUNT && len_q == '0))
    else $error("frame end did not return to hunting");

  a_payload_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.payload_valid |-> (res_o.status == ST_BUSY && phase_q == PH_PAYLOAD))
    else $error("payload item carries a terminating status");

  a_index_in_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && phase_q == PH_PAYLOAD) |-> (cnt_q < len_q))
    else $error("payload index reached the frame length");

endmodule

[rtl/crcfp_out_stage.sv]
// Result register that holds one finished item until the receiver takes it.
`timescale 1ns / 1ps
module crcfp_out_stage
  import crcfp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    out_stall_i,
  output logic    room_o,
  output logic    out_valid_o,
  output result_t res_o
);

  logic    full_q, full_d;
  result_t res_q;

  assign room_o = !full_q || !out_stall_i;

  always_comb begin
    full_d = full_q;
    if (load_i) begin
      full_d = 1'b1;
    end else if (!out_stall_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = full_q;
  assign res_o       = res_q;

endmodule

[rtl/crc_checked_frame_parser_core.sv]
// Top level of the CRC-checked byte-stream frame parser.
`timescale 1ns / 1ps
// Frame parser with CRC-16/CCITT check, one received byte per item.
//
// Input channel: in_valid_i / in_stall_o carry rx_byte_i. Output channel:
// out_valid_o / out_stall_i carry one result item per input item: status,
// the held type, length and sequence, and the payload byte with its index
// when the input byte was a payload byte. An item moves on a rising edge
// where valid is high and stall is low.
//
// Each item passes the input register, then single-pass logic into the result
// register. Throughput: one item per cycle while the receiver does not stall;
// the byte-wide CRC update and the length compare sit between the input
// register and the result register.
//
// While the receiver stalls, the finished result holds in the result
// register and one further item is still taken into the input register;
// only then does in_stall_o rise. Reset empties both registers, puts the
// parser into hunting and loads the register defaults (start byte 0,
// payload limit 256, CRC seed 0xFFFF). Write the configuration port only
// while no item is in flight.
module crc_checked_frame_parser_core
  import crcfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [7:0]          frame_type_o,
  output logic [15:0]         frame_length_o,
  output logic [7:0]          frame_seq_o,
  output logic                payload_valid_o,
  output logic [7:0]          payload_byte_o,
  output logic [15:0]         payload_index_o
);

  cfg_t       cfg;
  result_t    res_next;
  result_t    res_out;
  logic       in_full_q, in_full_d;
  logic [7:0] in_byte_q;
  logic       room;
  logic       adv;
  logic       in_take;

  crcfp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the held item into the parser whenever the result register has room.
  assign adv        = in_full_q && room;
  assign in_stall_o = in_full_q && !room;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_full_d = in_full_q;
    if (in_take) begin
      in_full_d = 1'b1;
    end else if (adv) begin
      in_full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else begin
      in_full_q <= in_full_d;
    end
  end

  // Hold the byte until it advances; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  crcfp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res_next)
  );

  crcfp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .res_i       (res_next),
    .out_stall_i (out_stall_i),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign status_o        = res_out.status;
  assign frame_type_o    = res_out.frame_type;
  assign frame_length_o  = res_out.frame_length;
  assign frame_seq_o     = res_out.frame_seq;
  assign payload_valid_o = res_out.payload_valid;
  assign payload_byte_o  = res_out.payload_byte;
  assign payload_index_o = res_out.payload_index;

endmodule

[verif/tb_crc_checked_frame_parser_core.sv]
// Self-checking testbench for the CRC-checked byte-stream frame parser core.
`timescale 1ns / 1ps
module tb_crc_checked_frame_parser_core;
  import crcfp_pkg::*;

  localparam int unsigned ClkPeriod     = 8;
  localparam int unsigned ResetCycles   = 3;
  // Settling margin for items still passing through the core.
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned HoldOffCycles = 64;
  // Longest correct quiet stretch is the hold-off above; allow many times that.
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned WholeFrame    = 32'h0010_0000;
  // Index that names no register; writes to it must leave everything alone.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT, PH_TYPE, PH_LEN_LO, PH_LEN_HI, PH_SEQ, PH_PAYLOAD, PH_CRC_LO, PH_CRC_HI
  } parse_phase_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [1:0]          status_o;
  logic [7:0]          frame_type_o;
  logic [15:0]         frame_length_o;
  logic [7:0]          frame_seq_o;
  logic                payload_valid_o;
  logic [7:0]          payload_byte_o;
  logic [15:0]         payload_index_o;

  crc_checked_frame_parser_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .frame_type_o   (frame_type_o),
    .frame_length_o (frame_length_o),
    .frame_seq_o    (frame_seq_o),
    .payload_valid_o(payload_valid_o),
    .payload_byte_o (payload_byte_o),
    .payload_index_o(payload_index_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Parser copy: register shadow and frame state, advanced once per accepted item.
  cfg_t         regs;
  parse_phase_e ph;
  logic [15:0]  len_field;
  logic [15:0]  byte_count;
  logic [15:0]  crc_acc;
  logic [7:0]   crc_lo;
  logic [7:0]   type_q;
  logic [7:0]   seq_q;

  result_t     frame_reports[$];   // reports owed by the core, oldest first
  logic [7:0]  frame_buf[$];
  int unsigned frame_bytes_sent  = 0;
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned hold_request      = 0;
  int unsigned fail_count        = 0;
  int unsigned quiet_cycles      = 0;

  // CRC-16/CCITT, one data bit at a time, MSB first.
  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  // Advance the parser copy by one received byte and return the report it owes.
  function automatic result_t parse_rx_byte(input logic [7:0] b);
    result_t r;
    logic    ends_frame;
    r          = '0;
    ends_frame = 1'b0;
    case (ph)
      PH_HUNT: begin
        if (b == regs.start_byte) begin
          crc_acc = regs.crc_seed;
          ph      = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_q  = b;
        crc_acc = crc_ccitt_step(crc_acc, b);
        ph      = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_field = {8'h00, b};
        crc_acc   = crc_ccitt_step(crc_acc, b);
        ph        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_field[15:8] = b;
        crc_acc         = crc_ccitt_step(crc_acc, b);
        if (len_field > regs.max_payload) begin
          r.status   = ST_TOOLONG;
          ends_frame = 1'b1;
        end else begin
          ph = PH_SEQ;
        end
      end
      PH_SEQ: begin
        seq_q      = b;
        crc_acc    = crc_ccitt_step(crc_acc, b);
        byte_count = 16'd0;
        ph         = (len_field == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = byte_count;
        crc_acc         = crc_ccitt_step(crc_acc, b);
        byte_count      = byte_count + 16'd1;
        if (byte_count >= len_field) ph = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        crc_lo = b;
        ph     = PH_CRC_HI;
      end
      default: begin
        r.status   = ({b, crc_lo} == crc_acc) ? ST_GOOD : ST_BADCRC;
        ends_frame = 1'b1;
      end
    endcase
    r.frame_type   = type_q;
    r.frame_length = len_field;
    r.frame_seq    = seq_q;
    if (ends_frame) begin
      ph         = PH_HUNT;
      len_field  = 16'd0;
      byte_count = 16'd0;
      crc_lo     = 8'h00;
      crc_acc    = regs.crc_seed;
    end
    return r;
  endfunction

  // Offer one byte; gaps go in before it, never while it waits on a stall.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    frame_reports.push_back(parse_rx_byte(b));
  endtask

  // Build a frame under the current registers and send its first cut_at bytes.
  // An over-limit length ends at the high length byte, so only the header goes.
  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
                            input logic [7:0] fseq, input bit corrupt,
                            input int unsigned cut_at);
    logic [15:0] crc;
    logic [7:0]  pb;
    frame_buf = {};
    frame_buf.push_back(regs.start_byte);
    frame_buf.push_back(ftype);
    frame_buf.push_back(flen[7:0]);
    frame_buf.push_back(flen[15:8]);
    if (flen <= regs.max_payload) begin
      frame_buf.push_back(fseq);
      for (int i = 0; i < flen; i++) begin
        pb = 8'($urandom_range(255));
        frame_buf.push_back(pb);
      end
      crc = regs.crc_seed;
      for (int i = 1; i < frame_buf.size(); i++) crc = crc_ccitt_step(crc, frame_buf[i]);
      if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(15));
      frame_buf.push_back(crc[7:0]);
      frame_buf.push_back(crc[15:8]);
    end
    for (int i = 0; i < frame_buf.size() && i < cut_at; i++) begin
      send_byte(frame_buf[i]);
      frame_bytes_sent++;
    end
  endtask

  // Drop valid and wait until every owed report has come back.
  task automatic drain_reports();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frame_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] value);
    drain_reports();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_START_BYTE:  regs.start_byte  = value[7:0];
      CFG_MAX_PAYLOAD: regs.max_payload = value;
      CFG_CRC_SEED:    regs.crc_seed    = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic randomise_registers();
    logic [15:0] limit;
    case ($urandom_range(3))
      0:       limit = 16'($urandom_range(8));
      1:       limit = 16'hFFFF;
      2:       limit = 16'($urandom_range(65535));
      default: limit = 16'($urandom_range(40));
    endcase
    write_reg(CFG_START_BYTE, 16'($urandom_range(255)));
    write_reg(CFG_MAX_PAYLOAD, limit);
    write_reg(CFG_CRC_SEED, ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(65535)));
  endtask

  // Reset-default registers: noise, a good frame, a zero-length frame with a
  // broken CRC, and lengths far and just over the limit.
  task automatic test_directed_frames();
    send_byte(8'h55);
    send_byte(8'hFF);
    send_frame(8'hFF, 16'd2, 8'h00, 1'b0, WholeFrame);
    send_frame(8'h00, 16'd0, 8'hFF, 1'b1, WholeFrame);
    send_frame(8'hA5, 16'hFFFF, 8'h5A, 1'b0, WholeFrame);
    send_frame(8'h81, 16'd257, 8'h18, 1'b0, WholeFrame);
    drain_reports();
  endtask

  // Register extremes, the spare index, and a limit change between length bytes.
  task automatic test_register_settings();
    write_reg(CFG_START_BYTE, 16'h00FF);
    write_reg(CFG_MAX_PAYLOAD, 16'h0000);
    write_reg(CFG_CRC_SEED, 16'h0000);
    send_byte(8'h00);
    send_frame(8'h3C, 16'd0, 8'hA5, 1'b0, WholeFrame);
    send_frame(8'h3C, 16'd1, 8'hA6, 1'b0, WholeFrame);
    write_reg(CFG_MAX_PAYLOAD, 16'hFFFF);
    write_reg(CFG_CRC_SEED, 16'h1D0F);
    write_reg(CFG_START_BYTE, 16'h007E);
    // Long enough for the payload index to pass a byte boundary.
    send_frame(8'h01, 16'd300, 8'h07, 1'b0, WholeFrame);
    write_reg(CfgIdxSpare, 16'hFFFF);
    send_frame(8'h02, 16'd3, 8'h08, 1'b1, WholeFrame);
    // Stop after the low length byte, tighten the limit, then finish the length.
    send_frame(8'h03, 16'h0105, 8'h09, 1'b0, 3);
    write_reg(CFG_MAX_PAYLOAD, 16'h0100);
    send_byte(8'h01);
    write_reg(CFG_MAX_PAYLOAD, MaxPayloadRst);
    drain_reports();
  endtask

  // Mostly well-formed frames with random content; the rest are over-limit
  // headers, truncated frames and line noise. Registers change every segment.
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_items);
    int unsigned stop_at;
    int unsigned seg_end;
    int unsigned pick;
    int unsigned lim;
    int unsigned flen;
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    stop_at           = frame_bytes_sent + n_items;
    while (frame_bytes_sent < stop_at) begin
      randomise_registers();
      seg_end = frame_bytes_sent + 90;
      while (frame_bytes_sent < seg_end && frame_bytes_sent < stop_at) begin
        pick = $urandom_range(99);
        lim  = (regs.max_payload < 12) ? regs.max_payload : 12;
        if (regs.max_payload >= 40 && $urandom_range(9) == 0) lim = 40;
        if (pick < 72) begin
          send_frame(8'($urandom_range(255)), 16'($urandom_range(lim)),
                     8'($urandom_range(255)), $urandom_range(99) < 15, WholeFrame);
        end else if (pick < 80 && regs.max_payload != 16'hFFFF) begin
          flen = regs.max_payload + 1 + $urandom_range(300);
          if (flen > 32'h0000_FFFF || $urandom_range(7) == 0) flen = 32'h0000_FFFF;
          send_frame(8'($urandom_range(255)), 16'(flen), 8'($urandom_range(255)), 1'b0,
                     WholeFrame);
        end else if (pick < 90) begin
          send_frame(8'($urandom_range(255)), 16'($urandom_range(lim)),
                     8'($urandom_range(255)), 1'b0, $urandom_range(1, 6));
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
        end
      end
    end
    drain_reports();
  endtask

  // Hold the output off for a long stretch while frames stream in back to back,
  // so both internal registers fill and the input stall rises.
  task automatic test_backpressure();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_request      = HoldOffCycles;
    for (int k = 0; k < 6; k++) begin
      send_frame(8'($urandom_range(255)), 16'($urandom_range(4, 8)),
                 8'($urandom_range(255)), 1'b0, WholeFrame);
    end
    drain_reports();
  endtask

  // Receiver: stall at the configured rate, or hold off for a requested stretch.
  int unsigned hold_left = 0;
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Compare every accepted report against the oldest one owed.
  always @(posedge clk_i) begin : check_reports
    result_t want;
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status        = status_e'(status_o);
      got.frame_type    = frame_type_o;
      got.frame_length  = frame_length_o;
      got.frame_seq     = frame_seq_o;
      got.payload_valid = payload_valid_o;
      got.payload_byte  = payload_byte_o;
      got.payload_index = payload_index_o;
      if (frame_reports.size() == 0) begin
        if (fail_count < 10) $display("%0t: report with none owed, status %0d", $realtime,
                                      status_o);
        fail_count++;
      end else begin
        want = frame_reports.pop_front();
        if (got.status !== want.status || got.frame_type !== want.frame_type ||
            got.frame_length !== want.frame_length || got.frame_seq !== want.frame_seq ||
            got.payload_valid !== want.payload_valid ||
            got.payload_byte !== want.payload_byte ||
            got.payload_index !== want.payload_index) begin
          if (fail_count < 10) begin
            $display("%0t: want st=%0d ty=%h len=%h seq=%h pv=%b pb=%h pi=%h", $realtime,
                     want.status, want.frame_type, want.frame_length, want.frame_seq,
                     want.payload_valid, want.payload_byte, want.payload_index);
            $display("%0t:  got st=%0d ty=%h len=%h seq=%h pv=%b pb=%h pi=%h", $realtime,
                     got.status, got.frame_type, got.frame_length, got.frame_seq,
                     got.payload_valid, got.payload_byte, got.payload_index);
          end
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("crc_checked_frame_parser_core: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_START_BYTE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    out_stall_i = 1'b0;
    regs        = '{start_byte: StartByteRst, max_payload: MaxPayloadRst,
                    crc_seed: CrcSeedRst};
    ph          = PH_HUNT;
    len_field   = 16'd0;
    byte_count  = 16'd0;
    crc_acc     = CrcSeedRst;
    crc_lo      = 8'h00;
    type_q      = 8'h00;
    seq_q       = 8'h00;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct   = 18;
    receiver_idle_pct = 57;
    test_directed_frames();
    test_register_settings();
    test_random_traffic(18, 57, 260);
    test_random_traffic(57, 18, 260);
    test_random_traffic(0, 0, 260);
    test_backpressure();

    drain_reports();
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (frame_reports.size() != 0) begin
      $display("%0d reports never arrived", frame_reports.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("crc_checked_frame_parser_core: match");
    end else begin
      $display("crc_checked_frame_parser_core: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/crcfp_pkg.sv
rtl/crcfp_cfg_regs.sv
rtl/crcfp_parser.sv
rtl/crcfp_out_stage.sv
rtl/crc_checked_frame_parser_core.sv
verif/tb_crc_checked_frame_parser_core.sv
